### rtl/rslm_pkg.sv
// Shared constants and types for the RTP stream loss monitor.
`timescale 1ns / 1ps

package rslm_pkg;

    // Header layout and codec constants
    localparam int unsigned RtpHdrBytes  = 12;
    localparam int unsigned ExtHdrBytes  = 4;
    localparam int unsigned G723SidBytes = 4;
    localparam int unsigned RtpVersion2  = 2;

    // Reciprocal of 10 for a 16-bit dividend: q = (x * 52429) >> 19
    localparam int unsigned Recip10      = 52429;
    localparam int unsigned Recip10Shift = 19;

    // Payload types with voice-frame checks
    localparam logic [6:0] PtPcmu  = 7'd0;
    localparam logic [6:0] PtG723  = 7'd4;
    localparam logic [6:0] PtPcma  = 7'd8;
    localparam logic [6:0] PtG722  = 7'd9;
    localparam logic [6:0] PtG728  = 7'd15;
    localparam logic [6:0] PtG729  = 7'd18;

    // Stream widths
    localparam int unsigned InDataW  = 96;
    localparam int unsigned OutDataW = 56;

    // One decoded RTP header
    typedef struct packed {
        logic        ext_captured;
        logic [15:0] ext_length_word;
        logic [15:0] app_length;
        logic [31:0] sync_source;
        logic [15:0] seq_num;
        logic [6:0]  payload_type;
        logic        marker_bit;
        logic [3:0]  csrc_count;
        logic        has_extension;
        logic [1:0]  hdr_version;
        logic        from_source;
    } t_in_item;

    // Result of payload stripping and voice classification
    typedef struct packed {
        logic        strip_ok;   // csrc bytes below app length
        logic [15:0] pay_bytes;
        logic        silent;
        logic        talk_end;
    } t_pay_info;

    // One result item
    typedef struct packed {
        logic        still_tracking;
        logic [31:0] dir_loss_count;
        logic        dir_reordered;
        logic        dir_silent;
        logic        talkspurt_end;
        logic [15:0] payload_bytes;
    } t_out_item;

endpackage

### rtl/rslm_payload.sv
// Header stripping and voice payload silence / talkspurt classification.
`timescale 1ns / 1ps

module rslm_payload (
    input  logic [15:0]         i_app_length,
    input  logic [3:0]          i_csrc_count,
    input  logic                i_has_extension,
    input  logic                i_ext_captured,
    input  logic [15:0]         i_ext_length_word,
    input  logic [6:0]          i_payload_type,
    input  logic                i_marker_bit,
    output rslm_pkg::t_pay_info o_info
);
    import rslm_pkg::*;

    logic [5:0]  csrc_bytes;
    logic [16:0] hdr_bytes;
    logic [16:0] ext_bytes;
    logic [15:0] len_base;
    logic [15:0] len_final;
    logic [31:0] recip_prod;
    logic [12:0] quot;
    logic [16:0] quot_x10;
    logic [16:0] rem10;
    logic        not_frame;
    logic        is_frame_pt;
    logic        is_g723;
    logic        silent;

    // Header byte counts
    assign csrc_bytes = {i_csrc_count, 2'b00};
    assign hdr_bytes  = 17'(RtpHdrBytes) + 17'(csrc_bytes);
    assign ext_bytes  = 17'(ExtHdrBytes) + 17'(i_ext_length_word);

    // Saturating strip of fixed header, CSRC words and extension
    always_comb begin
        len_base  = ({1'b0, i_app_length} > hdr_bytes) ?
                    16'({1'b0, i_app_length} - hdr_bytes) : 16'd0;
        len_final = len_base;
        if (i_has_extension && i_ext_captured) begin
            len_final = ({1'b0, len_base} > ext_bytes) ?
                        16'({1'b0, len_base} - ext_bytes) : 16'd0;
        end
    end

    // Remainder by 10 through reciprocal multiply
    assign recip_prod = 32'(len_final) * 32'(Recip10);
    assign quot       = recip_prod[31:Recip10Shift];
    assign quot_x10   = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    assign rem10      = {1'b0, len_final} - quot_x10;
    assign not_frame  = (rem10 != 17'd0);

    // Payload type decode
    always_comb begin
        is_frame_pt = 1'b0;
        is_g723     = 1'b0;
        case (i_payload_type)
            PtPcmu, PtPcma, PtG722, PtG728, PtG729: is_frame_pt = 1'b1;
            PtG723:                                  is_g723     = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        silent = 1'b0;
        if (is_frame_pt) begin
            silent = (len_final == 16'd0) || not_frame;
        end else if (is_g723) begin
            silent = (len_final == 16'd0) || (len_final == 16'(G723SidBytes));
        end
    end

    assign o_info.strip_ok  = ({10'd0, csrc_bytes} < i_app_length);
    assign o_info.pay_bytes = len_final;
    assign o_info.silent    = silent;
    assign o_info.talk_end  = (is_frame_pt || is_g723) && (silent || i_marker_bit);

endmodule

### rtl/rtp_stream_loss_monitor.sv
// Top level: per-direction RTP sequence loss, reorder and silence tracking.
`timescale 1ns / 1ps
// Result path: input reg, then result reg; the result reg loads once it is empty or being read.
// Throughput: one item per cycle while the receiver takes results; the per-direction state is
//   read and written between the two registers, so consecutive items see each other's updates.
// Reset (synchronous, active low): tracking live, all sequence, SSRC, loss counts and
//   marks cleared, both item registers empty.

module rtp_stream_loss_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, low bit up: hdr_version[1:0], has_extension, csrc_count[3:0], marker_bit,
    // payload_type[6:0], seq_num[15:0], sync_source[31:0], app_length[15:0],
    // ext_length_word[15:0], ext_captured
    input  logic [rslm_pkg::InDataW-1:0]   s_axis_tdata,
    // tuser: from_source
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, low bit up: still_tracking, dir_loss_count[31:0], dir_reordered,
    // dir_silent, talkspurt_end, payload_bytes[15:0], zero fill[3:0]
    output logic [rslm_pkg::OutDataW-1:0]  m_axis_tdata
);
    import rslm_pkg::*;

    // Item registers
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;

    // Per-direction state, index 1 = source side
    logic        r_track_live;
    logic [15:0] r_prev_seq  [2];
    logic [31:0] r_prev_ssrc [2];
    logic [31:0] r_lost      [2];
    logic        r_reorder   [2];
    logic        r_silence   [2];

    logic        adv;
    logic        in_acc;
    t_in_item    in_item;
    t_pay_info   pay;

    logic        d;
    logic        proc;
    logic        first_pkt;
    logic        ext_bad;
    logic        fail;
    logic        upd;
    logic [16:0] seq_expect;
    logic [31:0] gap;
    logic [31:0] n_lost;
    logic        n_reorder;
    logic        n_silence_d;
    logic        n_track_live;
    t_out_item   n_out;

    // Handshake
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_vld;

    // Input unpack
    assign in_item.hdr_version     = s_axis_tdata[1:0];
    assign in_item.has_extension   = s_axis_tdata[2];
    assign in_item.csrc_count      = s_axis_tdata[6:3];
    assign in_item.marker_bit      = s_axis_tdata[7];
    assign in_item.payload_type    = s_axis_tdata[14:8];
    assign in_item.seq_num         = s_axis_tdata[30:15];
    assign in_item.sync_source     = s_axis_tdata[62:31];
    assign in_item.app_length      = s_axis_tdata[78:63];
    assign in_item.ext_length_word = s_axis_tdata[94:79];
    assign in_item.ext_captured    = s_axis_tdata[95];
    assign in_item.from_source     = s_axis_tuser;

    // Payload stripping and codec checks
    rslm_payload u_payload (
        .i_app_length      (r_in.app_length),
        .i_csrc_count      (r_in.csrc_count),
        .i_has_extension   (r_in.has_extension),
        .i_ext_captured    (r_in.ext_captured),
        .i_ext_length_word (r_in.ext_length_word),
        .i_payload_type    (r_in.payload_type),
        .i_marker_bit      (r_in.marker_bit),
        .o_info            (pay)
    );

    // Tracking decisions
    assign d         = r_in.from_source;
    assign proc      = r_track_live && (r_in.hdr_version == 2'(RtpVersion2));
    assign first_pkt = (r_prev_seq[d] == 16'd0);
    assign ext_bad   = r_in.has_extension &&
                       ((r_in.ext_length_word > r_in.app_length) ||
                        ((r_in.app_length >= 16'(ExtHdrBytes)) &&
                         (r_in.ext_length_word < 16'(r_in.app_length - 16'(ExtHdrBytes)))));
    assign fail      = proc && !first_pkt &&
                       ((r_in.sync_source == 32'd0) ||
                        (r_prev_ssrc[d] != r_in.sync_source) || ext_bad);
    assign upd       = proc && !first_pkt && !fail;

    // Sequence step: gap, backward step or in order
    assign seq_expect = {1'b0, r_prev_seq[d]} + 17'd1;
    assign gap        = 32'(r_in.seq_num) - 32'(r_prev_seq[d]) - 32'd1;

    always_comb begin
        n_lost    = r_lost[d];
        n_reorder = r_reorder[d];
        if (upd && (seq_expect != {1'b0, r_in.seq_num})) begin
            if (r_in.seq_num < r_prev_seq[d]) begin
                if (r_lost[d] != 32'd0) begin
                    n_lost    = r_lost[d] - 32'd1;
                    n_reorder = 1'b1;
                end
            end else if (r_in.seq_num > r_prev_seq[d]) begin
                n_lost = r_lost[d] + gap;
            end
        end
    end

    always_comb begin
        n_silence_d = r_silence[d];
        if (fail) begin
            n_silence_d = 1'b0;
        end else if (upd && pay.strip_ok && pay.silent) begin
            n_silence_d = 1'b1;
        end
    end

    assign n_track_live = r_track_live && !fail;

    // Result assembly
    always_comb begin
        n_out.still_tracking = n_track_live;
        n_out.dir_loss_count = n_lost;
        n_out.dir_reordered  = n_reorder;
        n_out.dir_silent     = n_silence_d;
        n_out.talkspurt_end  = upd && pay.strip_ok && pay.talk_end;
        n_out.payload_bytes  = (upd && pay.strip_ok) ? pay.pay_bytes : 16'd0;
    end

    // Item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= in_item;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // Flow state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_live <= 1'b1;
            for (int i = 0; i < 2; i++) begin
                r_prev_seq[i]  <= '0;
                r_prev_ssrc[i] <= '0;
                r_lost[i]      <= '0;
                r_reorder[i]   <= 1'b0;
                r_silence[i]   <= 1'b0;
            end
        end else if (adv) begin
            r_track_live <= n_track_live;
            if (fail) begin
                r_silence[0] <= 1'b0;
                r_silence[1] <= 1'b0;
            end else begin
                r_silence[d] <= n_silence_d;
            end
            if (proc && !fail) begin
                r_prev_seq[d]  <= r_in.seq_num;
                r_prev_ssrc[d] <= r_in.sync_source;
            end
            r_lost[d]    <= n_lost;
            r_reorder[d] <= n_reorder;
        end
    end

    // Output pack
    assign m_axis_tdata = {4'd0, r_out.payload_bytes, r_out.talkspurt_end, r_out.dir_silent,
                           r_out.dir_reordered, r_out.dir_loss_count, r_out.still_tracking};

    // Checks
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_track_live |=> !r_track_live)
        else $error("tracking resumed after stop");

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.still_tracking) |->
        (!r_out.talkspurt_end && (r_out.payload_bytes == 16'd0)))
        else $error("stopped flow produced payload result");

    a_reorder_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_reorder[0] && r_reorder[1]) |=> (r_reorder[0] && r_reorder[1]))
        else $error("reorder mark cleared");

    a_stop_clears_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && fail) |=> (!r_silence[0] && !r_silence[1] && !r_track_live))
        else $error("stop did not clear silence marks");

endmodule

### tb/tb_rtp_stream_loss_monitor.sv
// Self-checking testbench for the RTP stream loss monitor: scoreboard class with predictor.
`timescale 1ns / 1ps

module tb_rtp_stream_loss_monitor;
    import rslm_pkg::*;

    localparam int unsigned CycleLimit  = 1_000_000;
    localparam int unsigned HoldCycles  = 300;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned PhaseItems  = 125;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum int {STOP_ZERO_SSRC, STOP_NEW_SSRC, STOP_EXT_LONG, STOP_EXT_SHORT} stop_kind_e;

    // Per-direction loss/reorder/silence predictor and queue of pending results
    class flow_loss_board;
        bit          live;
        bit [15:0]   last_seq [2];
        bit [31:0]   last_ssrc [2];
        bit [31:0]   lost [2];
        bit          reordered [2];
        bit          silent [2];
        t_out_item   due_results [$];
        int unsigned errors;

        function new();
            live = 1'b1;
            errors = 0;
            for (int d = 0; d < 2; d++) begin
                last_seq[d] = '0;
                last_ssrc[d] = '0;
                lost[d] = '0;
                reordered[d] = 1'b0;
                silent[d] = 1'b0;
            end
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
            errors++;
        endtask

        // Work out the result of one accepted header and queue it
        function void note_header(t_in_item h);
            t_out_item   r;
            bit          d;
            bit          bad;
            int unsigned alen;
            int unsigned xlen;
            int unsigned off;
            int unsigned len;
            int unsigned cur;
            int unsigned ps;
            d = h.from_source;
            r = '0;
            alen = h.app_length;
            xlen = h.ext_length_word;
            if (live && h.hdr_version == 2'(RtpVersion2)) begin
                if (last_seq[d] == 0) begin
                    // direction not seen yet: only record
                    last_seq[d] = h.seq_num;
                    last_ssrc[d] = h.sync_source;
                end else begin
                    bad = (h.sync_source == 0) || (h.sync_source != last_ssrc[d]);
                    if (!bad && h.has_extension)
                        bad = (xlen > alen) || (alen >= ExtHdrBytes && xlen < alen - ExtHdrBytes);
                    if (bad) begin
                        live = 1'b0;
                        silent[0] = 1'b0;
                        silent[1] = 1'b0;
                    end else begin
                        // sequence step: gap adds losses, backward step recovers one
                        ps = last_seq[d];
                        cur = h.seq_num;
                        if (cur < ps) begin
                            if (lost[d] != 0) begin
                                lost[d] = lost[d] - 1;
                                reordered[d] = 1'b1;
                            end
                        end else if (cur > ps) begin
                            lost[d] = lost[d] + (cur - ps - 1);
                        end
                        last_seq[d] = h.seq_num;
                        last_ssrc[d] = h.sync_source;
                        // header stripping and voice codec rules
                        off = h.csrc_count * 4;
                        if (off < alen) begin
                            len = (alen > RtpHdrBytes + off) ? alen - (RtpHdrBytes + off) : 0;
                            if (h.has_extension && h.ext_captured)
                                len = (len > ExtHdrBytes + xlen) ? len - (ExtHdrBytes + xlen) : 0;
                            r.payload_bytes = len[15:0];
                            case (h.payload_type)
                                PtPcmu, PtPcma, PtG722, PtG728, PtG729: begin
                                    if (len == 0 || (len % 10) != 0) begin
                                        r.talkspurt_end = 1'b1;
                                        silent[d] = 1'b1;
                                    end else begin
                                        r.talkspurt_end = h.marker_bit;
                                    end
                                end
                                PtG723: begin
                                    if (len == 0 || len == G723SidBytes) begin
                                        r.talkspurt_end = 1'b1;
                                        silent[d] = 1'b1;
                                    end else begin
                                        r.talkspurt_end = h.marker_bit;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            r.still_tracking = live;
            r.dir_loss_count = lost[d];
            r.dir_reordered = reordered[d];
            r.dir_silent = silent[d];
            due_results.push_back(r);
        endfunction

        // Compare one accepted result with the oldest pending one
        task check_result(logic [OutDataW-1:0] data);
            t_out_item got;
            t_out_item want;
            got.still_tracking = data[0];
            got.dir_loss_count = data[32:1];
            got.dir_reordered = data[33];
            got.dir_silent = data[34];
            got.talkspurt_end = data[35];
            got.payload_bytes = data[51:36];
            if (due_results.size() == 0) begin
                report("unexpected result item", 32'(data[31:0]), 32'd0);
            end else begin
                want = due_results.pop_front();
                if (got.still_tracking != want.still_tracking)
                    report("still_tracking", 32'(got.still_tracking), 32'(want.still_tracking));
                if (got.dir_loss_count != want.dir_loss_count)
                    report("dir_loss_count", got.dir_loss_count, want.dir_loss_count);
                if (got.dir_reordered != want.dir_reordered)
                    report("dir_reordered", 32'(got.dir_reordered), 32'(want.dir_reordered));
                if (got.dir_silent != want.dir_silent)
                    report("dir_silent", 32'(got.dir_silent), 32'(want.dir_silent));
                if (got.talkspurt_end != want.talkspurt_end)
                    report("talkspurt_end", 32'(got.talkspurt_end), 32'(want.talkspurt_end));
                if (got.payload_bytes != want.payload_bytes)
                    report("payload_bytes", 32'(got.payload_bytes), 32'(want.payload_bytes));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [InDataW-1:0]    s_axis_tdata;   // hdr_version .. ext_captured, low bit up
    logic                  s_axis_tuser;   // from_source
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OutDataW-1:0]   m_axis_tdata;   // still_tracking .. payload_bytes, zero fill

    flow_loss_board board = new();
    idle_mode_e     idle_mode = IDLE_BOTH;
    int unsigned    cycle_count = 0;
    int unsigned    hold_asks = 0;
    int unsigned    hold_seen = 0;
    int unsigned    hold_left = 0;

    rtp_stream_loss_monitor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAIL rtp_stream_loss_monitor");
            $finish;
        end
    end

    // Receiver: long hold-off on request, otherwise random stalls per idle mode
    always @(posedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_mode == IDLE_RECEIVER) begin
            m_axis_tready <= ($urandom_range(99, 0) >= 77);
        end else if (idle_mode == IDLE_BOTH) begin
            m_axis_tready <= ($urandom_range(99, 0) >= 22);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    function automatic bit sender_waits();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99, 0) < 77;
            IDLE_BOTH:   return $urandom_range(99, 0) < 22;
            default:     return 1'b0;
        endcase
    endfunction

    // Offer one header item and wait until it is taken
    task automatic send_header(t_in_item h);
        while (sender_waits()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {h.ext_captured, h.ext_length_word, h.app_length, h.sync_source,
                         h.seq_num, h.payload_type, h.marker_bit, h.csrc_count,
                         h.has_extension, h.hdr_version};
        s_axis_tuser <= h.from_source;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_header(h);
    endtask

    // Clean version-2 header that keeps the flow tracked
    function automatic t_in_item voice_header(bit d, logic [15:0] seq, logic [15:0] alen,
                                              logic [6:0] pt);
        t_in_item h;
        h = '0;
        h.from_source = d;
        h.hdr_version = 2'(RtpVersion2);
        h.seq_num = seq;
        h.app_length = alen;
        h.payload_type = pt;
        h.sync_source = (board.last_ssrc[d] != 0) ? board.last_ssrc[d] : 32'h1234_5678;
        return h;
    endfunction

    // Random header: mostly well-formed for the current flow state, or noise
    function automatic t_in_item random_header(bit noise);
        t_in_item     h;
        logic [127:0] raw;
        logic [15:0]  last;
        int unsigned  pick;
        bit           d;
        if (noise) begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom()};
            h = raw[96:0];
            h.hdr_version = ($urandom_range(2, 0) == 2) ? 2'd3 : 2'($urandom_range(1, 0));
            return h;
        end
        d = 1'($urandom_range(1, 0));
        h = '0;
        h.from_source = d;
        h.hdr_version = 2'(RtpVersion2);
        h.marker_bit = 1'($urandom_range(1, 0));
        h.csrc_count = ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 0)) : 4'd0;
        pick = $urandom_range(7, 0);
        case (pick)
            0: h.payload_type = PtPcmu;
            1: h.payload_type = PtPcma;
            2: h.payload_type = PtG722;
            3: h.payload_type = PtG728;
            4: h.payload_type = PtG729;
            5: h.payload_type = PtG723;
            default: h.payload_type = 7'($urandom_range(127, 0));
        endcase
        // lengths near whole voice frames, sometimes tiny or anything
        pick = $urandom_range(99, 0);
        if (pick < 15)
            h.app_length = 16'($urandom_range(65535, 0));
        else if (pick < 30)
            h.app_length = 16'($urandom_range(40, 0));
        else if (h.payload_type == PtG723)
            h.app_length = 16'(12 + 4 * h.csrc_count + 4 * $urandom_range(8, 0));
        else
            h.app_length = 16'(12 + 4 * h.csrc_count + 10 * $urandom_range(16, 0)
                               + (($urandom_range(3, 0) == 0) ? $urandom_range(9, 0) : 0));
        // extension: length kept within the accepted window
        h.ext_captured = 1'($urandom_range(1, 0));
        if ($urandom_range(3, 0) == 0) begin
            h.has_extension = 1'b1;
            if (h.app_length >= 4)
                h.ext_length_word = h.app_length - 16'($urandom_range(4, 0));
            else
                h.ext_length_word = 16'($urandom_range(h.app_length, 0));
        end else begin
            h.ext_length_word = 16'($urandom_range(65535, 0));
        end
        // sequence and SSRC follow the direction's stored state
        last = board.last_seq[d];
        if (last == 0) begin
            h.seq_num = 16'($urandom_range(65535, 1));
            h.sync_source = $urandom();
            if (h.sync_source == 0)
                h.sync_source = 32'h8000_0001;
        end else begin
            h.sync_source = board.last_ssrc[d];
            pick = $urandom_range(99, 0);
            if (pick < 55)
                h.seq_num = last + 16'd1;
            else if (pick < 70)
                h.seq_num = last + 16'($urandom_range(20, 2));
            else if (pick < 78)
                h.seq_num = 16'($urandom_range(65535, 0));
            else if (pick < 90)
                h.seq_num = last - 16'($urandom_range(5, 1));
            else if (pick < 95)
                h.seq_num = last;
            else
                h.seq_num = 16'd0;   // re-arms the direction with a fresh SSRC
        end
        return h;
    endfunction

    initial begin
        t_in_item    h;
        logic [15:0] s;
        stop_kind_e  kind;
        int unsigned n;

        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ignored versions with extreme fields
        h = '1;
        h.hdr_version = 2'd0;
        send_header(h);
        send_header('1);
        h = '0;
        h.hdr_version = 2'd1;
        send_header(h);

        // First packets of each direction only record
        h = voice_header(1'b1, 16'd100, 16'd172, PtPcmu);
        h.sync_source = 32'hFFFF_FFFF;
        send_header(h);
        h = voice_header(1'b0, 16'd65535, 16'd12, PtPcmu);
        h.sync_source = 32'h0000_0001;
        send_header(h);

        // In order, full frames, marker ends talkspurt
        h = voice_header(1'b1, 16'd101, 16'd172, PtPcmu);
        h.marker_bit = 1'b1;
        send_header(h);
        // gap, empty payload is silence
        send_header(voice_header(1'b1, 16'd110, 16'd12, PtPcma));
        // backward step, partial frame
        send_header(voice_header(1'b1, 16'd105, 16'd27, PtG722));
        // repeated sequence number
        send_header(voice_header(1'b1, 16'd105, 16'd52, PtG728));
        h = voice_header(1'b1, 16'd106, 16'd52, PtG729);
        h.marker_bit = 1'b1;
        send_header(h);
        // G.723 SID size, then a normal frame with marker
        send_header(voice_header(1'b1, 16'd107, 16'd16, PtG723));
        h = voice_header(1'b1, 16'd108, 16'd36, PtG723);
        h.marker_bit = 1'b1;
        send_header(h);
        // non-voice type, largest length and CSRC count
        h = voice_header(1'b1, 16'd109, 16'd65535, 7'd127);
        h.csrc_count = 4'd15;
        send_header(h);
        // short packet: CSRC words cover the whole length
        h = voice_header(1'b1, 16'd110, 16'd60, PtPcmu);
        h.csrc_count = 4'd15;
        send_header(h);
        send_header(voice_header(1'b1, 16'd111, 16'd0, PtPcmu));
        // extension captured, stripping saturates
        h = voice_header(1'b1, 16'd112, 16'd100, PtPcmu);
        h.has_extension = 1'b1;
        h.ext_length_word = 16'd96;
        h.ext_captured = 1'b1;
        send_header(h);
        // extension not captured
        h = voice_header(1'b1, 16'd113, 16'd100, PtPcmu);
        h.has_extension = 1'b1;
        h.ext_length_word = 16'd100;
        send_header(h);
        // extension on a packet shorter than its extension header
        h = voice_header(1'b1, 16'd114, 16'd2, PtPcmu);
        h.has_extension = 1'b1;
        h.ext_length_word = 16'd2;
        h.ext_captured = 1'b1;
        send_header(h);
        h = voice_header(1'b1, 16'd115, 16'd65535, 7'd96);
        h.has_extension = 1'b1;
        h.ext_length_word = 16'd65535;
        h.ext_captured = 1'b1;
        send_header(h);
        // wrap 65535 -> 0 with no losses, direction becomes unseen again
        send_header(voice_header(1'b0, 16'd0, 16'd12, PtPcmu));
        h = voice_header(1'b0, 16'd3, 16'd12, PtPcmu);
        h.sync_source = 32'h8000_0000;
        send_header(h);
        // largest forward gap, then a backward step recovers one
        send_header(voice_header(1'b0, 16'd65535, 16'd22, PtPcmu));
        send_header(voice_header(1'b0, 16'd2, 16'd22, PtPcmu));

        // Random traffic under each idle mode
        for (int p = 0; p < 4; p++) begin
            idle_mode = idle_mode_e'(p);
            n = 0;
            while (n < PhaseItems) begin
                if ($urandom_range(9, 0) == 0) begin
                    send_header(random_header(1'b1));
                end else begin
                    send_header(random_header(1'b0));
                    n++;
                end
            end
        end

        // Receiver holds off while items keep coming, so the input stalls
        idle_mode = IDLE_NONE;
        hold_asks++;
        for (int i = 0; i < 40; i++)
            send_header(random_header(1'b0));

        // Stop tracking by one of the stop conditions, then all state is frozen
        idle_mode = IDLE_BOTH;
        s = board.last_seq[1] + 16'd1;
        if (s == 0)
            s = 16'd1;
        send_header(voice_header(1'b1, s, 16'd172, PtPcmu));
        h = voice_header(1'b1, s + 16'd1, 16'd100, PtPcmu);
        kind = stop_kind_e'($urandom_range(3, 0));
        case (kind)
            STOP_ZERO_SSRC: h.sync_source = 32'd0;
            STOP_NEW_SSRC:  h.sync_source = ~h.sync_source;
            STOP_EXT_LONG: begin
                h.has_extension = 1'b1;
                h.ext_length_word = 16'd101;
            end
            default: begin
                h.has_extension = 1'b1;
                h.ext_length_word = 16'd95;
            end
        endcase
        send_header(h);
        for (int i = 0; i < 20; i++)
            send_header(random_header($urandom_range(3, 0) == 0));

        // Drain
        s_axis_tvalid <= 1'b0;
        idle_mode = IDLE_NONE;
        while (board.due_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (board.errors == 0)
            $display("PASS rtp_stream_loss_monitor");
        else
            $display("FAIL rtp_stream_loss_monitor");
        $finish;
    end

endmodule
